@@ hdl/pppna_pkg.sv @@
package pppna_pkg;

	typedef enum logic [3:0] {
		ST_INITIAL  = 4'd0,
		ST_STARTING = 4'd1,
		ST_CLOSED   = 4'd2,
		ST_STOPPED  = 4'd3,
		ST_CLOSING  = 4'd4,
		ST_STOPPING = 4'd5,
		ST_REQ_SENT = 4'd6,
		ST_ACK_RCVD = 4'd7,
		ST_ACK_SENT = 4'd8,
		ST_OPENED   = 4'd9
	} state_t;

	typedef enum logic [3:0] {
		EV_UP       = 4'd0,
		EV_DOWN     = 4'd1,
		EV_OPEN     = 4'd2,
		EV_CLOSE    = 4'd3,
		EV_EXPIRY   = 4'd4,
		EV_RCR_GOOD = 4'd5,
		EV_RCR_NAK  = 4'd6,
		EV_RCR_REJ  = 4'd7,
		EV_RCA      = 4'd8,
		EV_RCN      = 4'd9,
		EV_RTR      = 4'd10,
		EV_RTA      = 4'd11,
		EV_RUC      = 4'd12,
		EV_RXJ_OK   = 4'd13,
		EV_RXJ_BAD  = 4'd14
	} evt_code_t;

	typedef enum logic [1:0] {
		TERM_NONE = 2'd0,
		TERM_REQ  = 2'd1,
		TERM_ACK  = 2'd2
	} term_t;

	typedef enum logic [1:0] {
		REG_TERM_RESTARTS  = 2'd0,
		REG_CONF_RESTARTS  = 2'd1,
		REG_FAIL_RESTARTS  = 2'd2,
		REG_LAYER_PROTOCOL = 2'd3
	} reg_idx_t;

	localparam int SEND_REQ_BIT = 0;
	localparam int SEND_ACK_BIT = 1;
	localparam int SEND_NAK_BIT = 2;
	localparam int SEND_REJ_BIT = 3;

	localparam logic [15:0] LCP_PROTO = 16'hC021;

	localparam logic [7:0]  TERM_RESTARTS_RST  = 8'd2;
	localparam logic [7:0]  CONF_RESTARTS_RST  = 8'd5;
	localparam logic [7:0]  FAIL_RESTARTS_RST  = 8'd5;
	localparam logic [15:0] LAYER_PROTOCOL_RST = LCP_PROTO;

	typedef struct packed {
		logic [7:0]  term_restarts;
		logic [7:0]  conf_restarts;
		logic [7:0]  fail_restarts;
		logic [15:0] layer_protocol;
	} cfg_t;

	typedef struct packed {
		state_t     state;
		logic [7:0] retries;
		logic       timer;
		logic [7:0] term_id;
	} ctx_t;

	typedef struct packed {
		logic [3:0]  new_state;
		logic        tl_up;
		logic        tl_down;
		logic        tl_started;
		logic        tl_finished;
		logic [3:0]  conf_sends;
		logic [1:0]  term_send;
		logic [7:0]  term_frame_id;
		logic [15:0] term_protocol;
		logic        timer_on;
	} result_t;

	function automatic logic [7:0] sat_dec(input logic [7:0] v);
		sat_dec = (v != 8'd0) ? v - 8'd1 : 8'd0;
	endfunction

endpackage

@@ hdl/pppna_if.sv @@
interface pppna_evt_if;
	logic       valid;
	logic       ready;
	logic [3:0] mode;
	logic [7:0] peer_frame_id;

	modport source (output valid, output mode, output peer_frame_id, input ready);
	modport sink (input valid, input mode, input peer_frame_id, output ready);
endinterface

interface pppna_res_if;
	logic        valid;
	logic        ready;
	logic [3:0]  new_state;
	logic        tl_up;
	logic        tl_down;
	logic        tl_started;
	logic        tl_finished;
	logic [3:0]  conf_sends;
	logic [1:0]  term_send;
	logic [7:0]  term_frame_id;
	logic [15:0] term_protocol;
	logic        timer_on;

	modport source (
		output valid, output new_state, output tl_up, output tl_down,
		output tl_started, output tl_finished, output conf_sends,
		output term_send, output term_frame_id, output term_protocol,
		output timer_on, input ready
	);
	modport sink (
		input valid, input new_state, input tl_up, input tl_down,
		input tl_started, input tl_finished, input conf_sends,
		input term_send, input term_frame_id, input term_protocol,
		input timer_on, output ready
	);
endinterface

@@ hdl/pppna_regs.sv @@
module pppna_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output pppna_pkg::cfg_t    cfg
);

	pppna_pkg::cfg_t  cfg_q;
	pppna_pkg::reg_idx_t idx;
	logic wr_en;

	assign idx    = pppna_pkg::reg_idx_t'(paddr[3:2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.term_restarts  <= pppna_pkg::TERM_RESTARTS_RST;
			cfg_q.conf_restarts  <= pppna_pkg::CONF_RESTARTS_RST;
			cfg_q.fail_restarts  <= pppna_pkg::FAIL_RESTARTS_RST;
			cfg_q.layer_protocol <= pppna_pkg::LAYER_PROTOCOL_RST;
		end else if (wr_en) begin
			unique case (idx)
				pppna_pkg::REG_TERM_RESTARTS:  cfg_q.term_restarts  <= pwdata[7:0];
				pppna_pkg::REG_CONF_RESTARTS:  cfg_q.conf_restarts  <= pwdata[7:0];
				pppna_pkg::REG_FAIL_RESTARTS:  cfg_q.fail_restarts  <= pwdata[7:0];
				pppna_pkg::REG_LAYER_PROTOCOL: cfg_q.layer_protocol <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			pppna_pkg::REG_TERM_RESTARTS:  prdata = {24'd0, cfg_q.term_restarts};
			pppna_pkg::REG_CONF_RESTARTS:  prdata = {24'd0, cfg_q.conf_restarts};
			pppna_pkg::REG_FAIL_RESTARTS:  prdata = {24'd0, cfg_q.fail_restarts};
			pppna_pkg::REG_LAYER_PROTOCOL: prdata = {16'd0, cfg_q.layer_protocol};
			default:                       prdata = 32'd0;
		endcase
	end

endmodule

@@ hdl/pppna_fsm.sv @@
module pppna_fsm (
	input  pppna_pkg::ctx_t    ctx,
	input  pppna_pkg::cfg_t    cfg,
	input  logic [3:0]         mode,
	input  logic [7:0]         peer_frame_id,
	output pppna_pkg::ctx_t    ctx_next,
	output pppna_pkg::result_t res
);

	pppna_pkg::evt_code_t evt;
	pppna_pkg::state_t    st_nxt;
	logic       load_en;
	logic [7:0] load_val;
	logic       creq;
	logic       treq;
	logic       tack;
	logic       stop_tmr;
	logic       clr_cnt;
	logic       act_up;
	logic       act_down;
	logic       act_started;
	logic       act_finished;
	logic [3:0] sends_extra;
	logic [7:0] cnt;
	logic       tmr;
	logic [7:0] tid;

	assign evt = pppna_pkg::evt_code_t'(mode);

	// Decision: which actions the event calls for in the current state.
	always_comb begin
		st_nxt       = ctx.state;
		load_en      = 1'b0;
		load_val     = cfg.conf_restarts;
		creq         = 1'b0;
		treq         = 1'b0;
		tack         = 1'b0;
		stop_tmr     = 1'b0;
		clr_cnt      = 1'b0;
		act_up       = 1'b0;
		act_down     = 1'b0;
		act_started  = 1'b0;
		act_finished = 1'b0;
		sends_extra  = 4'd0;
		unique case (evt)
			pppna_pkg::EV_UP: begin
				unique case (ctx.state) inside
					pppna_pkg::ST_INITIAL: st_nxt = pppna_pkg::ST_CLOSED;
					pppna_pkg::ST_STARTING: begin
						load_en = 1'b1;
						creq    = 1'b1;
						st_nxt  = pppna_pkg::ST_REQ_SENT;
					end
					default: ;
				endcase
			end
			pppna_pkg::EV_DOWN: begin
				unique case (ctx.state) inside
					pppna_pkg::ST_CLOSED, pppna_pkg::ST_CLOSING:
						st_nxt = pppna_pkg::ST_INITIAL;
					pppna_pkg::ST_STOPPED: begin
						act_started = 1'b1;
						st_nxt      = pppna_pkg::ST_STARTING;
					end
					pppna_pkg::ST_STOPPING, pppna_pkg::ST_REQ_SENT,
					pppna_pkg::ST_ACK_RCVD, pppna_pkg::ST_ACK_SENT:
						st_nxt = pppna_pkg::ST_STARTING;
					pppna_pkg::ST_OPENED: begin
						act_down = 1'b1;
						st_nxt   = pppna_pkg::ST_STARTING;
					end
					default: ;
				endcase
			end
			pppna_pkg::EV_OPEN: begin
				unique case (ctx.state) inside
					pppna_pkg::ST_INITIAL: begin
						act_started = 1'b1;
						st_nxt      = pppna_pkg::ST_STARTING;
					end
					pppna_pkg::ST_CLOSING: st_nxt = pppna_pkg::ST_CLOSED;
					pppna_pkg::ST_CLOSED, pppna_pkg::ST_STOPPING,
					pppna_pkg::ST_STOPPED, pppna_pkg::ST_OPENED: begin
						act_started = (ctx.state == pppna_pkg::ST_STOPPED);
						act_down    = (ctx.state == pppna_pkg::ST_OPENED);
						load_en     = 1'b1;
						creq        = 1'b1;
						st_nxt      = pppna_pkg::ST_REQ_SENT;
					end
					default: ;
				endcase
			end
			pppna_pkg::EV_CLOSE: begin
				unique case (ctx.state) inside
					pppna_pkg::ST_STARTING: begin
						act_finished = 1'b1;
						st_nxt       = pppna_pkg::ST_INITIAL;
					end
					pppna_pkg::ST_STOPPED:  st_nxt = pppna_pkg::ST_CLOSED;
					pppna_pkg::ST_STOPPING: st_nxt = pppna_pkg::ST_CLOSING;
					pppna_pkg::ST_OPENED, pppna_pkg::ST_REQ_SENT,
					pppna_pkg::ST_ACK_RCVD, pppna_pkg::ST_ACK_SENT: begin
						act_down = (ctx.state == pppna_pkg::ST_OPENED);
						load_en  = 1'b1;
						load_val = cfg.term_restarts;
						treq     = 1'b1;
						st_nxt   = pppna_pkg::ST_CLOSING;
					end
					default: ;
				endcase
			end
			pppna_pkg::EV_EXPIRY: begin
				if (ctx.timer && ctx.retries != 8'd0) begin
					unique case (ctx.state) inside
						pppna_pkg::ST_CLOSING, pppna_pkg::ST_STOPPING: treq = 1'b1;
						pppna_pkg::ST_ACK_RCVD: begin
							creq   = 1'b1;
							st_nxt = pppna_pkg::ST_REQ_SENT;
						end
						pppna_pkg::ST_REQ_SENT, pppna_pkg::ST_ACK_SENT: creq = 1'b1;
						default: ;
					endcase
				end else if (ctx.timer) begin
					unique case (ctx.state) inside
						pppna_pkg::ST_CLOSING: begin
							stop_tmr     = 1'b1;
							act_finished = 1'b1;
							st_nxt       = pppna_pkg::ST_CLOSED;
						end
						pppna_pkg::ST_STOPPING, pppna_pkg::ST_ACK_RCVD,
						pppna_pkg::ST_REQ_SENT, pppna_pkg::ST_ACK_SENT: begin
							stop_tmr     = 1'b1;
							act_finished = 1'b1;
							st_nxt       = pppna_pkg::ST_STOPPED;
						end
						default: ;
					endcase
				end
			end
			pppna_pkg::EV_RCR_GOOD: begin
				unique case (ctx.state) inside
					pppna_pkg::ST_CLOSED: tack = 1'b1;
					pppna_pkg::ST_STOPPED, pppna_pkg::ST_REQ_SENT,
					pppna_pkg::ST_ACK_SENT: begin
						load_en = (ctx.state == pppna_pkg::ST_STOPPED);
						creq    = (ctx.state == pppna_pkg::ST_STOPPED);
						sends_extra[pppna_pkg::SEND_ACK_BIT] = 1'b1;
						st_nxt  = pppna_pkg::ST_ACK_SENT;
					end
					pppna_pkg::ST_ACK_RCVD: begin
						sends_extra[pppna_pkg::SEND_ACK_BIT] = 1'b1;
						stop_tmr = 1'b1;
						act_up   = 1'b1;
						st_nxt   = pppna_pkg::ST_OPENED;
					end
					pppna_pkg::ST_OPENED: begin
						act_down = 1'b1;
						creq     = 1'b1;
						sends_extra[pppna_pkg::SEND_ACK_BIT] = 1'b1;
						st_nxt   = pppna_pkg::ST_ACK_SENT;
					end
					default: ;
				endcase
			end
			pppna_pkg::EV_RCR_NAK, pppna_pkg::EV_RCR_REJ: begin
				unique case (ctx.state) inside
					pppna_pkg::ST_CLOSED: tack = 1'b1;
					pppna_pkg::ST_STOPPED, pppna_pkg::ST_ACK_SENT: begin
						load_en = (ctx.state == pppna_pkg::ST_STOPPED);
						creq    = (ctx.state == pppna_pkg::ST_STOPPED);
						st_nxt  = pppna_pkg::ST_REQ_SENT;
					end
					pppna_pkg::ST_OPENED: begin
						act_down = 1'b1;
						creq     = 1'b1;
						st_nxt   = pppna_pkg::ST_REQ_SENT;
					end
					default: ;
				endcase
				unique case (ctx.state) inside
					pppna_pkg::ST_STOPPED, pppna_pkg::ST_ACK_SENT, pppna_pkg::ST_REQ_SENT,
					pppna_pkg::ST_ACK_RCVD, pppna_pkg::ST_OPENED: begin
						if (evt == pppna_pkg::EV_RCR_NAK) begin
							sends_extra[pppna_pkg::SEND_NAK_BIT] = 1'b1;
						end else begin
							sends_extra[pppna_pkg::SEND_REJ_BIT] = 1'b1;
						end
					end
					default: ;
				endcase
			end
			pppna_pkg::EV_RCA: begin
				unique case (ctx.state) inside
					pppna_pkg::ST_CLOSED, pppna_pkg::ST_STOPPED: tack = 1'b1;
					pppna_pkg::ST_REQ_SENT: begin
						load_en = 1'b1;
						st_nxt  = pppna_pkg::ST_ACK_RCVD;
					end
					pppna_pkg::ST_ACK_RCVD: begin
						creq   = 1'b1;
						st_nxt = pppna_pkg::ST_REQ_SENT;
					end
					pppna_pkg::ST_ACK_SENT: begin
						stop_tmr = 1'b1;
						act_up   = 1'b1;
						st_nxt   = pppna_pkg::ST_OPENED;
					end
					pppna_pkg::ST_OPENED: begin
						act_down = 1'b1;
						creq     = 1'b1;
						st_nxt   = pppna_pkg::ST_REQ_SENT;
					end
					default: ;
				endcase
			end
			pppna_pkg::EV_RCN: begin
				unique case (ctx.state) inside
					pppna_pkg::ST_CLOSED, pppna_pkg::ST_STOPPED: tack = 1'b1;
					pppna_pkg::ST_REQ_SENT: begin
						load_en  = 1'b1;
						load_val = cfg.fail_restarts;
						creq     = 1'b1;
					end
					pppna_pkg::ST_ACK_RCVD: begin
						creq   = 1'b1;
						st_nxt = pppna_pkg::ST_REQ_SENT;
					end
					pppna_pkg::ST_ACK_SENT: begin
						load_en = 1'b1;
						creq    = 1'b1;
					end
					pppna_pkg::ST_OPENED: begin
						act_down = 1'b1;
						creq     = 1'b1;
						st_nxt   = pppna_pkg::ST_REQ_SENT;
					end
					default: ;
				endcase
			end
			pppna_pkg::EV_RTR: begin
				unique case (ctx.state) inside
					pppna_pkg::ST_OPENED: begin
						act_down = 1'b1;
						tack     = 1'b1;
						clr_cnt  = 1'b1;
						st_nxt   = pppna_pkg::ST_STOPPING;
					end
					pppna_pkg::ST_REQ_SENT, pppna_pkg::ST_ACK_RCVD,
					pppna_pkg::ST_ACK_SENT: begin
						tack   = 1'b1;
						st_nxt = pppna_pkg::ST_REQ_SENT;
					end
					default: treq = 1'b1;
				endcase
			end
			pppna_pkg::EV_RTA: begin
				unique case (ctx.state) inside
					pppna_pkg::ST_CLOSING: begin
						act_finished = 1'b1;
						st_nxt       = pppna_pkg::ST_CLOSED;
					end
					pppna_pkg::ST_STOPPING: begin
						act_finished = 1'b1;
						st_nxt       = pppna_pkg::ST_STOPPED;
					end
					pppna_pkg::ST_ACK_RCVD: st_nxt = pppna_pkg::ST_REQ_SENT;
					pppna_pkg::ST_OPENED: begin
						act_down = 1'b1;
						creq     = 1'b1;
						st_nxt   = pppna_pkg::ST_REQ_SENT;
					end
					default: ;
				endcase
			end
			pppna_pkg::EV_RUC: sends_extra[pppna_pkg::SEND_REJ_BIT] = 1'b1;
			pppna_pkg::EV_RXJ_OK: begin
				if (ctx.state == pppna_pkg::ST_ACK_RCVD) begin
					st_nxt = pppna_pkg::ST_REQ_SENT;
				end
			end
			pppna_pkg::EV_RXJ_BAD: begin
				unique case (ctx.state) inside
					pppna_pkg::ST_OPENED: begin
						act_down = 1'b1;
						treq     = 1'b1;
						st_nxt   = pppna_pkg::ST_STOPPING;
					end
					pppna_pkg::ST_CLOSING: begin
						act_finished = 1'b1;
						st_nxt       = pppna_pkg::ST_CLOSED;
					end
					pppna_pkg::ST_STOPPING, pppna_pkg::ST_REQ_SENT,
					pppna_pkg::ST_ACK_RCVD, pppna_pkg::ST_ACK_SENT: begin
						act_finished = 1'b1;
						st_nxt       = pppna_pkg::ST_STOPPED;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// Counter, timer and terminate id follow from the decision; a load
	// always comes before the decrement of a request.
	always_comb begin
		cnt = load_en ? load_val : ctx.retries;
		tmr = (ctx.timer || load_en) && !stop_tmr;
		if (creq || treq) begin
			cnt = pppna_pkg::sat_dec(cnt);
		end
		if (clr_cnt) begin
			cnt = 8'd0;
		end
		tid = treq ? ctx.term_id + 8'd1 : ctx.term_id;
	end

	always_comb begin
		ctx_next.state   = st_nxt;
		ctx_next.retries = cnt;
		ctx_next.timer   = tmr;
		ctx_next.term_id = tid;

		res.new_state      = st_nxt;
		res.tl_up          = act_up;
		res.tl_down        = act_down;
		res.tl_started     = act_started;
		res.tl_finished    = act_finished;
		res.conf_sends     = sends_extra;
		res.conf_sends[pppna_pkg::SEND_REQ_BIT] = creq;
		res.timer_on       = tmr;
		if (treq) begin
			res.term_send     = pppna_pkg::TERM_REQ;
			res.term_frame_id = tid;
			res.term_protocol = pppna_pkg::LCP_PROTO;
		end else if (tack) begin
			res.term_send     = pppna_pkg::TERM_ACK;
			res.term_frame_id = peer_frame_id;
			res.term_protocol = cfg.layer_protocol;
		end else begin
			res.term_send     = pppna_pkg::TERM_NONE;
			res.term_frame_id = 8'd0;
			res.term_protocol = 16'd0;
		end
	end

endmodule

@@ hdl/ppp_negotiation_automaton_unit.sv @@
// Channel  Direction  Handshake     Payload
// evt      in         valid/ready   mode, peer_frame_id
// result   out        valid/ready   new_state, layer flags, conf_sends, term_*, timer_on
// apb      in         psel/penable  paddr, pwdata, prdata (pready always high)
//
// An item is captured in an input register and its result moves into the output register
// once that register is free or its result is taken; while results are not stalled, one item is
// taken per cycle. The automaton state is updated when an item moves into the output
// register, so the next item sees it at once. Reset puts the automaton in the initial state
// with the counter, timer and terminate id cleared and the registers at their defaults.
// A stalled result holds the output register; the input register still takes one more item.
module ppp_negotiation_automaton_unit (
	input  logic        clk,
	input  logic        arst_n,
	pppna_evt_if.sink   evt,
	pppna_res_if.source result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	pppna_pkg::cfg_t    cfg;
	pppna_pkg::ctx_t    ctx_q;
	pppna_pkg::ctx_t    ctx_next;
	pppna_pkg::result_t res_comb;
	pppna_pkg::result_t res_s2;
	logic       valid_s1;
	logic [3:0] mode_s1;
	logic [7:0] pid_s1;
	logic       valid_s2;
	logic       adv;

	pppna_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pppna_fsm u_fsm (
		.ctx           (ctx_q),
		.cfg           (cfg),
		.mode          (mode_s1),
		.peer_frame_id (pid_s1),
		.ctx_next      (ctx_next),
		.res           (res_comb)
	);

	assign adv       = valid_s1 && (!valid_s2 || result.ready);
	assign evt.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			ctx_q.state   <= pppna_pkg::ST_INITIAL;
			ctx_q.retries <= 8'd0;
			ctx_q.timer   <= 1'b0;
			ctx_q.term_id <= 8'd0;
		end else begin
			if (evt.ready) begin
				valid_s1 <= evt.valid;
			end
			if (!valid_s2 || result.ready) begin
				valid_s2 <= valid_s1;
			end
			if (adv) begin
				ctx_q <= ctx_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			mode_s1 <= evt.mode;
			pid_s1  <= evt.peer_frame_id;
		end
		if (adv) begin
			res_s2 <= res_comb;
		end
	end

	assign result.valid          = valid_s2;
	assign result.new_state      = res_s2.new_state;
	assign result.tl_up          = res_s2.tl_up;
	assign result.tl_down        = res_s2.tl_down;
	assign result.tl_started     = res_s2.tl_started;
	assign result.tl_finished    = res_s2.tl_finished;
	assign result.conf_sends     = res_s2.conf_sends;
	assign result.term_send      = res_s2.term_send;
	assign result.term_frame_id  = res_s2.term_frame_id;
	assign result.term_protocol  = res_s2.term_protocol;
	assign result.timer_on       = res_s2.timer_on;

endmodule
